>>> sv/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle converter.
package qte_pkg;

    localparam int QW            = 16;
    localparam int SUM_W         = 35;
    localparam int A30_W         = 32;
    localparam int ROOT_W        = 31;
    localparam int RAD_W         = 61;
    localparam int RES_W         = 62;
    localparam int CORDIC_STAGES = 17;
    localparam int NORM_EXP      = 46;
    localparam int NORM_STEPS    = 7;
    localparam int CW            = 50;
    localparam int ZW            = 20;
    localparam int CORDIC_LAT    = 1 + NORM_STEPS + CORDIC_STAGES + 1;
    localparam int SQRT_ITERS    = 31;
    localparam int SQRT_LAT      = 2 + SQRT_ITERS;
    localparam int FIFO_DEPTH    = 4;

    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
    localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_y;
        logic signed [SUM_W-1:0] roll_x;
        logic signed [SUM_W-1:0] yaw_y;
        logic signed [SUM_W-1:0] yaw_x;
        logic signed [A30_W-1:0] a30;
        logic                    clamped;
    } qte_job_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 20'sd51472;
            1:       r = 20'sd30385;
            2:       r = 20'sd16055;
            3:       r = 20'sd8150;
            4:       r = 20'sd4091;
            5:       r = 20'sd2047;
            6:       r = 20'sd1024;
            7:       r = 20'sd512;
            8:       r = 20'sd256;
            9:       r = 20'sd128;
            10:      r = 20'sd64;
            11:      r = 20'sd32;
            12:      r = 20'sd16;
            13:      r = 20'sd8;
            14:      r = 20'sd4;
            15:      r = 20'sd2;
            default: r = 20'sd1;
        endcase
        return r;
    endfunction

endpackage

>>> sv/qte_if.sv
// Valid/ready channel interfaces for quaternion input and angle output.
interface qte_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    output ready);
endinterface

>>> sv/quaternion_to_euler_angles.sv
// Throughput: one transaction per cycle while the output is not stalled, set by the
// fully pipelined square root and CORDICs.
// Back-end depth is 61 stages (33 square root, 26 CORDIC, entry and output registers).
// A 4-entry queue lets the front end keep accepting while the output stalls.
// rst_n (asynchronous, active low) clears all valid bits and queue pointers.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    qte_in_if.sink     quat_in,
    qte_out_if.source  angle_out
);

    localparam int LAT = 2 + SQRT_LAT + CORDIC_LAT;

    qte_job_t job, head, s0_reg;
    logic push, push_ok, pop, full, empty, en;
    logic [LAT-1:0] v_reg;
    logic signed [15:0] roll_c, yaw_c, pitch_c, roll_d, yaw_d;
    logic signed [A30_W-1:0] a30_d;
    logic [ROOT_W-1:0] root;
    logic clamped_d;
    logic signed [15:0] roll_reg, yaw_reg, pitch_neg;
    logic signed [14:0] pitch_reg;
    logic clamped_reg;

    assign en      = !v_reg[LAT-1] || angle_out.ready;
    assign pop     = en && !empty;
    assign push_ok = !full || pop;

    qte_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .quat_in(quat_in),
        .push_ok(push_ok), .push(push), .job(job)
    );

    qte_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .din(job),
        .pop(pop), .dout(head), .full(full), .empty(empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], !empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_reg <= head;
    end

    qte_cordic #(.LIM(PI_Q13)) u_roll (
        .clk(clk), .en(en), .y_in(s0_reg.roll_y), .x_in(s0_reg.roll_x), .angle(roll_c)
    );

    qte_cordic #(.LIM(PI_Q13)) u_yaw (
        .clk(clk), .en(en), .y_in(s0_reg.yaw_y), .x_in(s0_reg.yaw_x), .angle(yaw_c)
    );

    qte_isqrt u_isqrt (.clk(clk), .en(en), .a30(s0_reg.a30), .root(root));

    qte_delay #(.W(A30_W), .DEPTH(SQRT_LAT)) u_a30_dly (
        .clk(clk), .en(en), .din(s0_reg.a30), .dout(a30_d)
    );

    qte_cordic #(.LIM(HALF_PI_Q13)) u_pitch (
        .clk(clk), .en(en), .y_in(SUM_W'(a30_d)), .x_in(SUM_W'(root)), .angle(pitch_c)
    );

    qte_delay #(.W(32), .DEPTH(SQRT_LAT)) u_ry_dly (
        .clk(clk), .en(en), .din({roll_c, yaw_c}), .dout({roll_d, yaw_d})
    );

    qte_delay #(.W(1), .DEPTH(SQRT_LAT + CORDIC_LAT)) u_clamp_dly (
        .clk(clk), .en(en), .din(s0_reg.clamped), .dout(clamped_d)
    );

    assign pitch_neg = -pitch_c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg    <= roll_d;
            yaw_reg     <= yaw_d;
            pitch_reg   <= pitch_neg[14:0];
            clamped_reg <= clamped_d;
        end
    end

    assign angle_out.valid         = v_reg[LAT-1];
    assign angle_out.roll_angle    = roll_reg;
    assign angle_out.pitch_angle   = pitch_reg;
    assign angle_out.yaw_angle     = yaw_reg;
    assign angle_out.pitch_clamped = clamped_reg;

endmodule

>>> sv/qte_front.sv
// Front end: accepts quaternions, forms products, sums and the arcsine clamp flag.
module qte_front import qte_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic     clk,
    input  logic     rst_n,
    qte_in_if.sink   quat_in,
    input  logic     push_ok,
    output logic     push,
    output qte_job_t job
);

    localparam int AW = (2 * FRAC_BITS + 2 > SUM_W) ? 2 * FRAC_BITS + 2 : SUM_W;
    localparam int SH = 2 * FRAC_BITS - 30;
    localparam logic signed [AW-1:0] UNIT = AW'(1) << (2 * FRAC_BITS);

    logic p_valid_reg, p_valid_next;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wx_reg, yz_reg, wz_reg, xy_reg, xz_reg, wy_reg;
    logic signed [SUM_W-1:0] a_sum;
    logic signed [AW-1:0] a_wide, a_sat, a_shift;
    logic take;

    assign quat_in.ready = !p_valid_reg || push_ok;
    assign take          = quat_in.valid && quat_in.ready;
    assign push          = p_valid_reg && push_ok;
    assign p_valid_next  = quat_in.ready ? quat_in.valid : p_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ww_reg <= quat_in.quat_w * quat_in.quat_w;
            xx_reg <= quat_in.quat_x * quat_in.quat_x;
            yy_reg <= quat_in.quat_y * quat_in.quat_y;
            zz_reg <= quat_in.quat_z * quat_in.quat_z;
            wx_reg <= quat_in.quat_w * quat_in.quat_x;
            yz_reg <= quat_in.quat_y * quat_in.quat_z;
            wz_reg <= quat_in.quat_w * quat_in.quat_z;
            xy_reg <= quat_in.quat_x * quat_in.quat_y;
            xz_reg <= quat_in.quat_x * quat_in.quat_z;
            wy_reg <= quat_in.quat_w * quat_in.quat_y;
        end
    end

    always_comb
    begin
        a_sum   = (SUM_W'(xz_reg) - SUM_W'(wy_reg)) <<< 1;
        a_wide  = AW'(a_sum);
        if (a_wide > UNIT)
            a_sat = UNIT;
        else if (a_wide < -UNIT)
            a_sat = -UNIT;
        else
            a_sat = a_wide;
        job.roll_y  = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        job.roll_x  = SUM_W'(ww_reg) - SUM_W'(xx_reg) - SUM_W'(yy_reg) + SUM_W'(zz_reg);
        job.yaw_y   = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        job.yaw_x   = SUM_W'(ww_reg) + SUM_W'(xx_reg) - SUM_W'(yy_reg) - SUM_W'(zz_reg);
        job.a30     = a_shift[A30_W-1:0];
        job.clamped = (a_wide > UNIT) || (a_wide < -UNIT);
    end

    generate
        if (SH >= 0)
        begin : g_down
            assign a_shift = a_sat >>> SH;
        end
        else
        begin : g_up
            assign a_shift = a_sat <<< (-SH);
        end
    endgenerate

endmodule

>>> sv/qte_fifo.sv
// Short transaction queue between front end and back end.
module qte_fifo import qte_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  qte_job_t din,
    input  logic     pop,
    output qte_job_t dout,
    output logic     full,
    output logic     empty
);

    localparam int PW = $clog2(FIFO_DEPTH);

    qte_job_t mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg, count_next;

    assign full  = count_reg == (PW + 1)'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

>>> sv/qte_delay.sv
// Stall-aware delay line for side data traveling alongside the datapath.
module qte_delay #(
    parameter int W     = 16,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
                tap_reg[k] <= tap_reg[k-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

>>> sv/qte_isqrt.sv
// Pipelined cosine term: floor(sqrt(2^60 - a^2)) for the arcsine path.
module qte_isqrt import qte_pkg::*; (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [A30_W-1:0] a30,
    output logic [ROOT_W-1:0]       root
);

    logic [A30_W:0]  mag;
    logic [30:0]     mag_c;
    logic            full_reg;
    logic [29:0]     hh_reg, hl_reg, ll_reg;
    logic [RAD_W-1:0] sq, t0_reg;
    logic [RAD_W-1:0] t_reg [SQRT_ITERS];
    logic [RES_W-1:0] r_reg [SQRT_ITERS];

    always_comb
    begin
        mag   = a30[A30_W-1] ? -(A30_W + 1)'(a30) : (A30_W + 1)'(a30);
        mag_c = (mag > (A30_W + 1)'(1 << 30)) ? 31'(1 << 30) : mag[30:0];
        sq    = (RAD_W'(hh_reg) << 30) + (RAD_W'(hl_reg) << 16) + RAD_W'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            full_reg <= mag_c[30];
            hh_reg   <= mag_c[29:15] * mag_c[29:15];
            hl_reg   <= mag_c[29:15] * mag_c[14:0];
            ll_reg   <= mag_c[14:0] * mag_c[14:0];
            t0_reg   <= full_reg ? '0 : (RAD_W'(1) << 60) - sq;
        end
    end

    generate
        for (genvar j = 0; j < SQRT_ITERS; j++)
        begin : g_iter
            localparam logic [RES_W-1:0] BIT = RES_W'(1) << (60 - 2 * j);
            logic [RAD_W-1:0] t_in;
            logic [RES_W-1:0] r_in, trial;
            if (j == 0)
            begin : g_first
                assign t_in = t0_reg;
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign t_in = t_reg[j-1];
                assign r_in = r_reg[j-1];
            end
            assign trial = r_in + BIT;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (RES_W'(t_in) >= trial)
                    begin
                        t_reg[j] <= t_in - trial[RAD_W-1:0];
                        r_reg[j] <= (r_in >> 1) + BIT;
                    end
                    else
                    begin
                        t_reg[j] <= t_in;
                        r_reg[j] <= r_in >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = r_reg[SQRT_ITERS-1][ROOT_W-1:0];

endmodule

>>> sv/qte_cordic.sv
// Pipelined vectoring CORDIC atan2 with quadrant fold, normalization and Q3.13 rounding.
module qte_cordic import qte_pkg::*; #(
    parameter logic signed [15:0] LIM = 16'sd25736
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SUM_W-1:0] y_in,
    input  logic signed [SUM_W-1:0] x_in,
    output logic signed [15:0]      angle
);

    localparam int PW = SUM_W + 1;

    logic signed [PW-1:0] px_next, py_next, px_reg, py_reg;
    logic signed [ZW-1:0] pz_next, pz_reg;
    logic signed [CW-1:0] nx_reg [NORM_STEPS];
    logic signed [CW-1:0] ny_reg [NORM_STEPS];
    logic signed [ZW-1:0] nz_reg [NORM_STEPS];
    logic signed [CW-1:0] cx_reg [CORDIC_STAGES];
    logic signed [CW-1:0] cy_reg [CORDIC_STAGES];
    logic signed [ZW-1:0] cz_reg [CORDIC_STAGES];
    logic signed [ZW-1:0] rz;
    logic signed [15:0]   angle_reg;

    // fold left half-plane into the right one
    always_comb
    begin
        px_next = PW'(x_in);
        py_next = PW'(y_in);
        pz_next = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                px_next = PW'(y_in);
                py_next = -PW'(x_in);
                pz_next = HALF_PI_Q16;
            end
            else
            begin
                px_next = -PW'(y_in);
                py_next = PW'(x_in);
                pz_next = -HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
    end

    generate
        for (genvar k = 0; k < NORM_STEPS; k++)
        begin : g_norm
            localparam int S  = (k < NORM_STEPS - 1) ? (32 >> k) : 1;
            localparam int TH = (k < NORM_STEPS - 1) ? NORM_EXP - S : NORM_EXP;
            logic signed [CW-1:0] x_in_k, y_in_k;
            logic signed [ZW-1:0] z_in_k;
            logic [CW-1:0] m;
            if (k == 0)
            begin : g_first
                assign x_in_k = CW'(px_reg);
                assign y_in_k = CW'(py_reg);
                assign z_in_k = pz_reg;
            end
            else
            begin : g_rest
                assign x_in_k = nx_reg[k-1];
                assign y_in_k = ny_reg[k-1];
                assign z_in_k = nz_reg[k-1];
            end
            assign m = x_in_k | (y_in_k < 0 ? -y_in_k : y_in_k);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nz_reg[k] <= z_in_k;
                    if ((m >> TH) == '0)
                    begin
                        nx_reg[k] <= x_in_k <<< S;
                        ny_reg[k] <= y_in_k <<< S;
                    end
                    else
                    begin
                        nx_reg[k] <= x_in_k;
                        ny_reg[k] <= y_in_k;
                    end
                end
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_rot
            localparam logic signed [ZW-1:0] ANG = atan_q16(i);
            logic signed [CW-1:0] x_i, y_i;
            logic signed [ZW-1:0] z_i;
            if (i == 0)
            begin : g_first
                assign x_i = nx_reg[NORM_STEPS-1];
                assign y_i = ny_reg[NORM_STEPS-1];
                assign z_i = nz_reg[NORM_STEPS-1];
            end
            else
            begin : g_rest
                assign x_i = cx_reg[i-1];
                assign y_i = cy_reg[i-1];
                assign z_i = cz_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (y_i == '0)
                    begin
                        cx_reg[i] <= x_i;
                        cy_reg[i] <= y_i;
                        cz_reg[i] <= z_i;
                    end
                    else if (y_i > 0)
                    begin
                        cx_reg[i] <= x_i + (y_i >>> i);
                        cy_reg[i] <= y_i - (x_i >>> i);
                        cz_reg[i] <= z_i + ANG;
                    end
                    else
                    begin
                        cx_reg[i] <= x_i - (y_i >>> i);
                        cy_reg[i] <= y_i + (x_i >>> i);
                        cz_reg[i] <= z_i - ANG;
                    end
                end
            end
        end
    endgenerate

    assign rz = (cz_reg[CORDIC_STAGES-1] + ZW'(4)) >>> 3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rz > ZW'(LIM))
                angle_reg <= LIM;
            else if (rz < -ZW'(LIM))
                angle_reg <= -LIM;
            else
                angle_reg <= rz[15:0];
        end
    end

    assign angle = angle_reg;

endmodule

>>> sv/qte_checker.sv
// Port-level checker for the quaternion to Euler angle converter, bound to the top level.
module qte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] roll_angle,
    input logic signed [14:0] pitch_angle,
    input logic signed [15:0] yaw_angle,
    input logic               pitch_clamped
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(roll_angle) && $stable(pitch_angle)
            && $stable(yaw_angle) && $stable(pitch_clamped))
        else $error("output payload changed while stalled");

    a_ry_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736
            && yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)
        else $error("roll or yaw out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)
        else $error("pitch out of range");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(angle_out.valid),
    .out_ready(angle_out.ready),
    .roll_angle(angle_out.roll_angle),
    .pitch_angle(angle_out.pitch_angle),
    .yaw_angle(angle_out.yaw_angle),
    .pitch_clamped(angle_out.pitch_clamped)
);

>>> tb/qte_tb_if.sv
// Testbench clock and reset generator.
module tb_clock_reset (
    output logic clk,
    output logic rst_n
);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

endmodule

>>> tb/tb_quaternion_to_euler_angles.sv
// Testbench: random and directed quaternions checked against a bit-exact angle predictor.
module tb_quaternion_to_euler_angles;
    import qte_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    localparam longint NORM_LIM  = 64'sd1 << 46;
    localparam int     IDLE_LIM  = 20000;
    localparam int     DRAIN_LAT = 80;

    class angle_scoreboard;
        angles_t pending[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        function void note_quat(input logic signed [15:0] w, x, y, z);
            pending.push_back(predict_angles(w, x, y, z));
        endfunction

        function void check_angles(input angles_t got);
            angles_t exp_a;
            if (pending.size() == 0)
            begin
                $error("unexpected transaction roll=%0d", got.roll);
                errors++;
                return;
            end
            exp_a = pending.pop_front();
            if (got.roll !== exp_a.roll)
            begin
                $error("roll_angle exp %0d got %0d", exp_a.roll, got.roll);
                errors++;
            end
            if (got.pitch !== exp_a.pitch)
            begin
                $error("pitch_angle exp %0d got %0d", exp_a.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== exp_a.yaw)
            begin
                $error("yaw_angle exp %0d got %0d", exp_a.yaw, got.yaw);
                errors++;
            end
            if (got.clamped !== exp_a.clamped)
            begin
                $error("pitch_clamped exp %0b got %0b", exp_a.clamped, got.clamped);
                errors++;
            end
        endfunction
    endclass

    function automatic longint fl_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_tab(input int i);
        longint t[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
        return t[i];
    endfunction

    function automatic longint vec_angle(input longint yi, input longint xi);
        longint x, y, z, nx, ny, dx, dy;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y;
                ny = -x;
                z = 102944;
            end
            else
            begin
                nx = -y;
                ny = x;
                z = -102944;
            end
            x = nx;
            y = ny;
        end
        while ((x < 0 ? -x : x) < NORM_LIM && (y < 0 ? -y : y) < NORM_LIM)
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 17; i++)
        begin
            if (y == 0)
                break;
            dx = fl_shr(y, i);
            dy = fl_shr(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += atan_tab(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_tab(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(input longint a, input longint lim);
        longint r;
        r = fl_shr(a + 4, 3);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned t);
        longint unsigned res, b, v;
        v = t;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic angles_t predict_angles(input logic signed [15:0] qw, qx, qy, qz);
        longint w, x, y, z, unity, a, a30, c, p;
        longint unsigned mag;
        int sh;
        angles_t r;
        w = qw;
        x = qx;
        y = qy;
        z = qz;
        unity = 64'sd1 << 28;
        r.clamped = 1'b0;
        r.roll = 16'(round_q13(vec_angle(2 * (w * x + y * z),
                                         w * w - x * x - y * y + z * z), 25736));
        r.yaw = 16'(round_q13(vec_angle(2 * (w * z + x * y),
                                        w * w + x * x - y * y - z * z), 25736));
        a = 2 * (x * z - w * y);
        if (a > unity)
        begin
            a = unity;
            r.clamped = 1'b1;
        end
        if (a < -unity)
        begin
            a = -unity;
            r.clamped = 1'b1;
        end
        sh = 28 - 30;
        a30 = a * (64'sd1 << (-sh));
        mag = a30 < 0 ? -a30 : a30;
        if (mag > (64'd1 << 30))
            mag = 64'd1 << 30;
        c = int_sqrt((64'd1 << 60) - mag * mag);
        p = -round_q13(vec_angle(a30, c), 12868);
        r.pitch = p[14:0];
        return r;
    endfunction

    logic clk;
    logic rst_n;

    qte_in_if  quat_in ();
    qte_out_if angle_out ();

    tb_clock_reset clkgen (.clk(clk), .rst_n(rst_n));

    quaternion_to_euler_angles dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .quat_in  (quat_in.sink),
        .angle_out(angle_out.source)
    );

    angle_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  quiet_cycles;
    bit  stim_done;

    initial
    begin
        sb = new();
        quat_in.valid = 1'b0;
        quat_in.quat_w = '0;
        quat_in.quat_x = '0;
        quat_in.quat_y = '0;
        quat_in.quat_z = '0;
        angle_out.ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 1'b0;
        stim_done = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (quat_in.valid && quat_in.ready)
                sb.note_quat(quat_in.quat_w, quat_in.quat_x, quat_in.quat_y, quat_in.quat_z);
            if (angle_out.valid && angle_out.ready)
                sb.check_angles({angle_out.roll_angle, angle_out.pitch_angle,
                                 angle_out.yaw_angle, angle_out.pitch_clamped});
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || recv_hold)
            angle_out.ready <= 1'b0;
        else
            angle_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((quat_in.valid && quat_in.ready) || (angle_out.valid && angle_out.ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        quiet_cycles = 0;
        wait (quiet_cycles >= IDLE_LIM);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_quat(input logic signed [15:0] w, x, y, z);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            quat_in.valid <= 1'b0;
            @(negedge clk);
        end
        quat_in.valid <= 1'b1;
        quat_in.quat_w <= w;
        quat_in.quat_x <= x;
        quat_in.quat_y <= y;
        quat_in.quat_z <= z;
        @(posedge clk);
        while (!quat_in.ready)
            @(posedge clk);
    endtask

    task automatic end_burst;
        @(negedge clk);
        quat_in.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(9))
            0:       return 16'($urandom());
            1:       return $urandom_range(4) == 0 ? 16'sh8000 : 16'sh7fff;
            2:       return 16'sd0;
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $urandom_range(20000) - 10000.0;
        b = $urandom_range(20000) - 10000.0;
        c = $urandom_range(20000) - 10000.0;
        d = $urandom_range(20000) - 10000.0;
        if ($urandom_range(5) == 0)
            b = 0.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1.0;
            n = 1.0;
        end
        send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            else
                send_unit_quat();
        end
        end_burst();
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        @(posedge rst_n);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(16384, 0, 16384, 0);
        send_quat(16384, 0, -16384, 0);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(0, -16384, 0, 0);
        send_quat(0, 0, 0, -16384);
        send_quat(0, 16384, 0, 16384);
        send_quat(16384, -16384, 16384, -16384);
        send_quat(-1, -1, -1, -1);
        send_quat(1, 0, 0, 0);
        send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        send_quat(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
        end_burst();

        send_idle_pct = 30;
        recv_idle_pct = 53;
        run_random(140);

        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                recv_hold = 1'b0;
            end
            run_random(80);
        join

        wait_drained();
        send_idle_pct = 53;
        recv_idle_pct = 30;
        run_random(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(110);

        wait_drained();
        repeat (DRAIN_LAT) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
sv/qte_pkg.sv
sv/qte_if.sv
sv/qte_front.sv
sv/qte_fifo.sv
sv/qte_delay.sv
sv/qte_isqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler_angles.sv
sv/qte_checker.sv
tb/qte_tb_if.sv
tb/tb_quaternion_to_euler_angles.sv
